[sv/spt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted pair translation table package
// Shared sizes, codes, request and response types and sequencer states.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int ENTRY_W     = 2 * KEY_W;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_MAP    = 2'd2;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_MISS    = 2'd1;
   localparam logic [1:0] STS_INVALID = 2'd2;
   localparam logic [1:0] STS_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] addr_a;
      logic [KEY_W-1:0] addr_b;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [KEY_W-1:0] mapped_addr;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_KEY_ACT,
      S_SHUP_RD,
      S_SHUP_WR,
      S_SHDN_RD,
      S_SHDN_WR,
      S_KEY_NEXT
   } state_type;

endpackage

[sv/spt_ram.sv]
// ----------------------------------------------------------------------------
// Table entry RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module spt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sv/sorted_pair_translation_table_unit.sv]
// ----------------------------------------------------------------------------
// Sorted pair translation table unit
// Sorted table of address keys with XOR words: create, delete and map.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                 Direction  Handshake
//   request   start, req_data       in         taken when start && !busy
//   response  rsp_valid, rsp_data   out        one-cycle strobe, no back-pressure
//
// One request gives one response. A key lookup is a binary search over the
// entry RAM, each probe a read and then a compare, up to ceil(log2(count+1))
// probes; a map does one lookup, and a create or delete does one per key of
// the pair. Inserting a new key or removing one moves the entries above it
// one slot, each moved entry read and then written. Equal create or delete
// pairs and unused actions answer from idle without a search. Synchronous
// reset empties the table at once by clearing the entry count; busy stays high
// until the response issues.

module sorted_pair_translation_table_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  spt_pkg::req_type req_data,
   output logic            rsp_valid,
   output spt_pkg::rsp_type rsp_data
);
   import spt_pkg::*;

   state_type        state_ff, state_in;
   logic [1:0]       action_ff, action_in;
   logic [KEY_W-1:0] addr_a_ff, addr_a_in;
   logic [KEY_W-1:0] addr_b_ff, addr_b_in;
   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             hit_ff, hit_in;
   logic [KEY_W-1:0] hit_xor_ff, hit_xor_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fail_ff, fail_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic [KEY_W-1:0] cur_key, word;
   logic [CNT_W-1:0] mid, free_slots, need;
   logic [KEY_W-1:0] rd_key;

   assign cur_key    = phase_ff ? addr_b_ff : addr_a_ff;
   assign word       = addr_a_ff ^ addr_b_ff;
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign free_slots = CNT_W'(TABLE_DEPTH) - count_ff;
   assign need       = phase_ff ? CNT_W'(1) : CNT_W'(2);
   assign rd_key     = rd_data[ENTRY_W-1:KEY_W];

   spt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      addr_a_ff   <= addr_a_in;
      addr_b_ff   <= addr_b_in;
      phase_ff    <= phase_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hit_ff      <= hit_in;
      hit_xor_ff  <= hit_xor_in;
      idx_ff      <= idx_in;
      fail_ff     <= fail_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hit_in       = hit_ff;
      hit_xor_in   = hit_xor_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      fail_in      = fail_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = lo_ff[IDX_W-1:0];
      wr_data      = {cur_key, word};
      rd_en        = 1'b0;
      rd_addr      = mid[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = req_data.action;
               addr_a_in = req_data.addr_a;
               addr_b_in = req_data.addr_b;
               phase_in  = 1'b0;
               lo_in     = '0;
               hi_in     = count_ff;
               hit_in    = 1'b0;
               fail_in   = 1'b0;
               if ((req_data.action == ACT_CREATE || req_data.action == ACT_DELETE) &&
                   req_data.addr_a == req_data.addr_b) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STS_INVALID, mapped_addr: '0};
               end else if (req_data.action == ACT_CREATE ||
                            req_data.action == ACT_DELETE ||
                            req_data.action == ACT_MAP) begin
                  state_in = S_SRCH_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STS_OK, mapped_addr: '0};
               end
            end
         end

         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               state_in = S_SRCH_CMP;
            end else begin
               state_in = S_KEY_ACT;
            end
         end

         S_SRCH_CMP: begin
            // Keys are unique, so an equal probe already marks the final position.
            if (rd_key < cur_key) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            if (rd_key == cur_key) begin
               hit_in     = 1'b1;
               hit_xor_in = rd_data[KEY_W-1:0];
            end
            state_in = S_SRCH_RD;
         end

         S_KEY_ACT: begin
            case (action_ff)
               ACT_MAP: begin
                  rsp_valid_in = 1'b1;
                  if (hit_ff) begin
                     rsp_data_in = '{status: STS_OK, mapped_addr: addr_a_ff ^ hit_xor_ff};
                  end else begin
                     rsp_data_in = '{status: STS_MISS, mapped_addr: addr_a_ff};
                  end
                  state_in = S_IDLE;
               end
               ACT_CREATE: begin
                  if (hit_ff) begin
                     wr_en    = 1'b1;
                     state_in = S_KEY_NEXT;
                  end else if (free_slots < need) begin
                     fail_in  = 1'b1;
                     state_in = S_KEY_NEXT;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHUP_RD;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     idx_in   = lo_ff;
                     state_in = S_SHDN_RD;
                  end else begin
                     state_in = S_KEY_NEXT;
                  end
               end
            endcase
         end

         S_SHUP_RD: begin
            if (idx_ff > lo_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(idx_ff - CNT_W'(1));
               state_in = S_SHUP_WR;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_KEY_NEXT;
            end
         end

         S_SHUP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data;
            idx_in   = idx_ff - CNT_W'(1);
            state_in = S_SHUP_RD;
         end

         S_SHDN_RD: begin
            if ((idx_ff + CNT_W'(1)) < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(idx_ff + CNT_W'(1));
               state_in = S_SHDN_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_KEY_NEXT;
            end
         end

         S_SHDN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_SHDN_RD;
         end

         S_KEY_NEXT: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               state_in = S_SRCH_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: fail_ff ? STS_FULL : STS_OK, mapped_addr: '0};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
